### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define RSIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define RSIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define RSIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RSIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### design/rsis_pkg.sv
// ----------------------------------------------------------------------------
// rsis_pkg
// shared types and constants of the random sample indexed set
// ----------------------------------------------------------------------------
package rsis_pkg;

	localparam int DEF_VALUE_RANGE = 1024;
	localparam int VALUE_W         = 10;
	localparam int REQ_W           = 2;
	localparam int STATUS_W        = 2;
	localparam int COUNT_OUT_W     = 11;
	localparam int RAND_W          = 32;
	localparam int VR_EXT_W        = 17;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SAMPLE = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_NOCHANGE = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOOK  = 6'b000010,
		S_CHECK = 6'b000100,
		S_DIV   = 6'b001000,
		S_FETCH = 6'b010000,
		S_CLEAR = 6'b100000
	} state_t;

endpackage

### design/rsis_ram.sv
// ----------------------------------------------------------------------------
// rsis_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rsis_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/rsis_mod.sv
// ----------------------------------------------------------------------------
// rsis_mod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module rsis_mod #(
	parameter int CW = 11
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rsis_pkg::RAND_W-1:0] dividend,
	input  logic [CW-1:0]             divisor,
	output logic                      done,
	output logic [CW-1:0]             rem
);

	import rsis_pkg::*;

	localparam int STEP_W = $clog2(RAND_W);

	logic [RAND_W-1:0] dvd_q;
	logic [CW-1:0]     div_q;
	logic [CW-1:0]     rem_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [CW:0]       trial;
	logic [CW-1:0]     rem_next;

	// shift in the next dividend bit and subtract if it fits
	always_comb begin
		trial = {rem_q, dvd_q[RAND_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = CW'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(RAND_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[RAND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### design/random_sample_indexed_set_core.sv
// ----------------------------------------------------------------------------
// random_sample_indexed_set_core
// set of small values kept as a dense member array plus a value-to-slot map
// ----------------------------------------------------------------------------
//
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------
// request   | start, busy (beat: start&!busy) | req_type, value, position, random_word
// result    | result_strobe (one cycle)  | value_out, status, member_count
//
// steps of a beat, from accept to the next possible accept:
//   insert / remove : slot map read, dense read, check and write back
//   read            : one dense read; out of range: reply from idle
//   sample          : remainder unit, then one dense read; empty: reply from idle
// the result strobe rises the cycle after the decision and cannot be held off
// reset is asynchronous active low and clears count and control; after reset
// the slot map is cleared one entry per cycle with busy high, so every map read
// returns a defined slot and membership is proven by a round trip
// through both maps
//
`include "assert_macros.svh"

module random_sample_indexed_set_core #(
	parameter int VALUE_RANGE = rsis_pkg::DEF_VALUE_RANGE
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rsis_pkg::REQ_W-1:0]         req_type,
	input  logic [rsis_pkg::VALUE_W-1:0]       value,
	input  logic [rsis_pkg::VALUE_W-1:0]       position,
	input  logic [rsis_pkg::RAND_W-1:0]        random_word,
	output logic                               result_strobe,
	output logic [rsis_pkg::VALUE_W-1:0]       value_out,
	output logic [rsis_pkg::STATUS_W-1:0]      status,
	output logic [rsis_pkg::COUNT_OUT_W-1:0]   member_count
);

	import rsis_pkg::*;

	// slot index, count and value-map geometry
	localparam int SW  = $clog2(VALUE_RANGE);
	localparam int CW  = $clog2(VALUE_RANGE + 1);
	localparam int VVR = (VALUE_RANGE < (1 << VALUE_W)) ? VALUE_RANGE : (1 << VALUE_W);
	localparam int VIW = $clog2(VVR);
	localparam int XW  = (CW > VALUE_W) ? CW : VALUE_W;

	state_t              state_q;
	req_t                req_q;
	logic [VALUE_W-1:0]  val_q;
	logic [SW-1:0]       idx_q;
	logic [VALUE_W-1:0]  last_q;
	logic [CW-1:0]       count_q;
	logic [VIW-1:0]      clr_q;

	logic                result_strobe_q;
	logic [VALUE_W-1:0]  value_out_q;
	status_t             status_q;

	// memory ports
	logic                slot_we;
	logic [VIW-1:0]      slot_waddr;
	logic [SW-1:0]       slot_wdata;
	logic [VIW-1:0]      slot_raddr;
	logic [SW-1:0]       slot_rdata;
	logic                dense_we;
	logic [SW-1:0]       dense_waddr;
	logic [VALUE_W-1:0]  dense_wdata;
	logic [SW-1:0]       dense_raddr;
	logic [VALUE_W-1:0]  dense_rdata;

	// remainder unit
	logic                mod_start;
	logic                mod_done;
	logic [CW-1:0]       mod_rem;

	logic                accept;
	req_t                req_in;
	logic                value_ok;
	logic                pos_bad;
	logic                present;
	logic                full;
	logic                reply_src;
	logic                ins_grow;

	assign accept   = start && (state_q == S_IDLE);
	assign req_in   = req_t'(req_type);
	assign value_ok = VR_EXT_W'(value) < VR_EXT_W'(VALUE_RANGE);
	assign pos_bad  = XW'(position) >= XW'(count_q);
	assign full     = count_q == CW'(VALUE_RANGE);
	// a value is a member iff its map slot lies below count and points back to it
	assign present  = (CW'(idx_q) < count_q) && (dense_rdata == val_q);

	assign mod_start = accept && (req_in == REQ_SAMPLE) && (count_q != '0);

	// read address steering
	always_comb begin
		slot_raddr = VIW'(value);
		if (state_q == S_LOOK) begin
			dense_raddr = slot_rdata;
		end else if (state_q == S_DIV) begin
			dense_raddr = SW'(mod_rem);
		end else if (req_in == REQ_REMOVE) begin
			// last dense entry, moved into the freed slot on remove
			dense_raddr = SW'(count_q - 1'b1);
		end else begin
			dense_raddr = SW'(position);
		end
	end

	// slot map clearing after reset, write back on a successful insert or remove
	always_comb begin
		slot_we     = 1'b0;
		dense_we    = 1'b0;
		slot_waddr  = VIW'(val_q);
		slot_wdata  = SW'(count_q);
		dense_waddr = SW'(count_q);
		dense_wdata = val_q;
		if (state_q == S_CLEAR) begin
			slot_we    = 1'b1;
			slot_waddr = clr_q;
			slot_wdata = '0;
		end else if (state_q == S_CHECK) begin
			if (req_q == REQ_INSERT) begin
				slot_we  = !present && !full;
				dense_we = !present && !full;
			end else begin
				slot_we     = present;
				dense_we    = present;
				slot_waddr  = VIW'(last_q);
				slot_wdata  = idx_q;
				dense_waddr = idx_q;
				dense_wdata = last_q;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			count_q         <= '0;
			clr_q           <= '0;
			result_strobe_q <= 1'b0;
		end else begin
			result_strobe_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VIW'(VVR - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (req_in)
							REQ_INSERT, REQ_REMOVE: begin
								if (value_ok) begin
									state_q <= S_LOOK;
								end else begin
									result_strobe_q <= 1'b1;
								end
							end
							REQ_SAMPLE: begin
								if (count_q != '0) begin
									state_q <= S_DIV;
								end else begin
									result_strobe_q <= 1'b1;
								end
							end
							REQ_READ: begin
								if (!pos_bad) begin
									state_q <= S_FETCH;
								end else begin
									result_strobe_q <= 1'b1;
								end
							end
							default: begin
								result_strobe_q <= 1'b1;
							end
						endcase
					end
				end
				S_LOOK: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q         <= S_IDLE;
					result_strobe_q <= 1'b1;
					if (req_q == REQ_INSERT) begin
						if (!present && !full) begin
							count_q <= count_q + 1'b1;
						end
					end else if (present) begin
						count_q <= count_q - 1'b1;
					end
				end
				S_DIV: begin
					if (mod_done) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q         <= S_IDLE;
					result_strobe_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request fields, working registers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_in;
			val_q <= value;
			value_out_q <= '0;
			case (req_in)
				REQ_INSERT, REQ_REMOVE: status_q <= ST_NOCHANGE;
				REQ_SAMPLE:             status_q <= ST_EMPTY;
				REQ_READ:               status_q <= ST_RANGE;
				default:                status_q <= ST_NOCHANGE;
			endcase
		end
		if (state_q == S_LOOK) begin
			idx_q  <= slot_rdata;
			last_q <= dense_rdata;
		end
		if (state_q == S_CHECK) begin
			if (req_q == REQ_INSERT) begin
				status_q <= (!present && !full) ? ST_DONE : ST_NOCHANGE;
			end else begin
				status_q <= present ? ST_DONE : ST_NOCHANGE;
			end
		end
		if (state_q == S_FETCH) begin
			value_out_q <= dense_rdata;
			status_q    <= ST_DONE;
		end
	end

	rsis_ram #(
		.WIDTH (SW),
		.DEPTH (VVR)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	rsis_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (VALUE_RANGE)
	) u_dense_ram (
		.clk   (clk),
		.we    (dense_we),
		.waddr (dense_waddr),
		.wdata (dense_wdata),
		.raddr (dense_raddr),
		.rdata (dense_rdata)
	);

	rsis_mod #(
		.CW (CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (random_word),
		.divisor  (count_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign busy          = state_q != S_IDLE;
	assign result_strobe = result_strobe_q;
	assign value_out     = value_out_q;
	assign status        = status_q;
	assign member_count  = COUNT_OUT_W'(count_q);

	// cycles that may raise the strobe on the next edge
	assign reply_src = accept || (state_q == S_CHECK) || (state_q == S_FETCH);
	// check cycle of an insert that takes effect
	assign ins_grow  = (state_q == S_CHECK) && (req_q == REQ_INSERT) && !present && !full;

	// remainder unit is only ever started from idle on a nonempty set
	`RSIS_ASSERT_IMP(a_mod_start, clk, arst_n, mod_start, count_q != '0)

	// a remainder only ever comes back while the sequencer waits for it
	`RSIS_ASSERT_IMP(a_mod_done, clk, arst_n, mod_done, state_q == S_DIV)

	// every result follows an immediate reply, a check or a fetch
	`RSIS_ASSERT_IMP(a_strobe_src, clk, arst_n, result_strobe_q, $past(reply_src))

	// a completed insert grows the set by exactly one
	`RSIS_ASSERT_NXT(a_ins_grow, clk, arst_n, ins_grow, count_q == $past(count_q) + 1'b1)

endmodule
